// ===== rtl/ols_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and constants of the online least-squares update unit.
// ----------------------------------------------------------------------------
package ols_pkg;

	// sizes of the row and of the fixed-point words
	localparam int MAX_FEATURES_DEF = 8;
	localparam int ROW_FEATURES     = 8;
	localparam int X_W              = 16;
	localparam int Q_W              = 32;
	localparam int ACC_W            = 64;
	localparam int CFG_W            = 4;

	// shared divider geometry
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 48;
	localparam int DIV_QUO_W = 32;

	localparam logic [Q_W-1:0]   ONE_Q16      = 32'h0001_0000;
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd2;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_E_RD,
		ST_E_MUL,
		ST_E_ACC,
		ST_E_FIN,
		ST_Z_RD,
		ST_Z_DIV,
		ST_Z_WAIT,
		ST_Z_MUL,
		ST_Z_ACC,
		ST_H_FIN,
		ST_U_RD,
		ST_U_MUL,
		ST_U_DIV,
		ST_U_WAIT,
		ST_U_WR,
		ST_DONE
	} st_t;

	// divide request toward the serial divider
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_QUO_W-1:0] quo;
	} div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ols_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ols_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ols_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/ols_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ols_div
// Restoring serial divider, one quotient bit per cycle, 32 quotient bits.
// The caller keeps num below den * 2^32.
// ----------------------------------------------------------------------------
module ols_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ols_pkg::div_req_t req,
	output ols_pkg::div_stat_t    stat
);
	import ols_pkg::*;

	localparam int CNT_W = $clog2(DIV_QUO_W);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_QUO_W-1:0] lo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, lo_q[DIV_QUO_W-1]};
		ge    = (trial >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_QUO_W]);
			lo_q  <= req.num[DIV_QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
			lo_q  <= {lo_q[DIV_QUO_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quo  = lo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");

endmodule
`default_nettype wire

// ===== rtl/online_least_squares_update_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// online_least_squares_update_unit
// Per-row coefficient update with a diagonal preconditioner, Q16.16 state.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | clear_fit, feature_0..7, target
//  out     | output    | out_valid/out_stall | residual, leverage, coef_0..7
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (active_features)
//
//  Each row uses the shared 32-step divider twice per feature, by SS_i for
//  z_i and by (1 + h) for the step.  Reset clears the valid bits of both
//  state RAMs at once; no clearing pass.  A new row is taken only in idle;
//  a waiting result does not block the next row until that row finishes.
// ----------------------------------------------------------------------------
module online_least_squares_update_unit #(
	parameter int MAX_FEATURES = ols_pkg::MAX_FEATURES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            clear_fit,
	input  wire logic signed [ols_pkg::X_W-1:0]  feature_0,
	input  wire logic signed [ols_pkg::X_W-1:0]  feature_1,
	input  wire logic signed [ols_pkg::X_W-1:0]  feature_2,
	input  wire logic signed [ols_pkg::X_W-1:0]  feature_3,
	input  wire logic signed [ols_pkg::X_W-1:0]  feature_4,
	input  wire logic signed [ols_pkg::X_W-1:0]  feature_5,
	input  wire logic signed [ols_pkg::X_W-1:0]  feature_6,
	input  wire logic signed [ols_pkg::X_W-1:0]  feature_7,
	input  wire logic signed [ols_pkg::X_W-1:0]  target,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [ols_pkg::Q_W-1:0]       residual,
	output logic        [ols_pkg::Q_W-1:0]       leverage,
	output logic signed [ols_pkg::Q_W-1:0]       coef_0,
	output logic signed [ols_pkg::Q_W-1:0]       coef_1,
	output logic signed [ols_pkg::Q_W-1:0]       coef_2,
	output logic signed [ols_pkg::Q_W-1:0]       coef_3,
	output logic signed [ols_pkg::Q_W-1:0]       coef_4,
	output logic signed [ols_pkg::Q_W-1:0]       coef_5,
	output logic signed [ols_pkg::Q_W-1:0]       coef_6,
	output logic signed [ols_pkg::Q_W-1:0]       coef_7,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ols_pkg::CFG_W-1:0]       cfg_data
);
	import ols_pkg::*;

	localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam logic [AW-1:0] LAST_K = AW'(MAX_FEATURES - 1);

	st_t state_q, state_d;
	logic [AW-1:0]           k_q;
	logic [CFG_W-1:0]        active_features_q;
	logic [MAX_FEATURES-1:0] entry_valid_q;

	logic signed [X_W-1:0]   x_q [MAX_FEATURES];
	logic signed [Q_W-1:0]   z_q [MAX_FEATURES];
	logic signed [Q_W-1:0]   coef_work_q [MAX_FEATURES];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [47:0]      prod_q;
	logic signed [Q_W-1:0]   e_q;
	logic [Q_W-1:0]          h_q;
	logic [DIV_DEN_W-1:0]    den_q;
	logic signed [Q_W-1:0]   b_cur_q;
	logic [Q_W-1:0]          ss_cur_q;
	logic [63:0]             m_q;
	logic [16:0]             sq_q;

	logic                    out_valid_q;
	logic signed [Q_W-1:0]   residual_q;
	logic [Q_W-1:0]          leverage_q;
	logic signed [Q_W-1:0]   out_coef_q [MAX_FEATURES];

	logic signed [X_W-1:0]   feat_w [ROW_FEATURES];
	logic signed [X_W-1:0]   x_in [MAX_FEATURES];
	logic signed [Q_W-1:0]   coef_out_w [ROW_FEATURES];

	logic [Q_W-1:0]          coef_rdata, ss_rdata;
	logic signed [Q_W-1:0]   b_rd;
	logic [Q_W-1:0]          ss_rd, d_rd;
	logic signed [X_W-1:0]   x_k;
	logic [X_W-1:0]          xmag;
	logic signed [Q_W-1:0]   z_k;
	logic [Q_W-1:0]          zmag, emag;
	logic signed [ACC_W-1:0] rs_e, rs_h;
	logic signed [Q_W-1:0]   e_sat;
	logic [Q_W-1:0]          h_sat;
	logic [32:0]             h_plus;
	logic signed [33:0]      b_sum;
	logic signed [Q_W-1:0]   b_new;
	logic [32:0]             ss_sum;
	logic [Q_W-1:0]          ss_new;
	logic                    ram_we;
	logic                    out_free;
	logic                    in_acc;
	div_req_t                div_req;
	div_stat_t               div_stat;

	// row fields as an array
	assign feat_w[0] = feature_0;
	assign feat_w[1] = feature_1;
	assign feat_w[2] = feature_2;
	assign feat_w[3] = feature_3;
	assign feat_w[4] = feature_4;
	assign feat_w[5] = feature_5;
	assign feat_w[6] = feature_6;
	assign feat_w[7] = feature_7;

	// mask features beyond the active count
	for (genvar j = 0; j < MAX_FEATURES; j++) begin : g_xin
		if (j < ROW_FEATURES) begin : g_row
			assign x_in[j] = (32'(active_features_q) > j) ? feat_w[j] : '0;
		end else begin : g_none
			assign x_in[j] = '0;
		end
	end

	// coefficient ports, zero beyond the stored entries
	for (genvar j = 0; j < ROW_FEATURES; j++) begin : g_cout
		if (j < MAX_FEATURES) begin : g_have
			assign coef_out_w[j] = out_coef_q[j];
		end else begin : g_none
			assign coef_out_w[j] = '0;
		end
	end

	assign coef_0    = coef_out_w[0];
	assign coef_1    = coef_out_w[1];
	assign coef_2    = coef_out_w[2];
	assign coef_3    = coef_out_w[3];
	assign coef_4    = coef_out_w[4];
	assign coef_5    = coef_out_w[5];
	assign coef_6    = coef_out_w[6];
	assign coef_7    = coef_out_w[7];
	assign residual  = residual_q;
	assign leverage  = leverage_q;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	// state memories
	ols_ram #(.WIDTH(Q_W), .DEPTH(MAX_FEATURES)) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (k_q),
		.wdata (b_new),
		.raddr (k_q),
		.rdata (coef_rdata)
	);

	ols_ram #(.WIDTH(Q_W), .DEPTH(MAX_FEATURES)) u_ss_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (k_q),
		.wdata (ss_new),
		.raddr (k_q),
		.rdata (ss_rdata)
	);

	ols_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// per-entry operands, unwritten entries read as reset values
	always_comb begin
		b_rd  = entry_valid_q[k_q] ? coef_rdata : '0;
		ss_rd = entry_valid_q[k_q] ? ss_rdata : ONE_Q16;
		d_rd  = (ss_rd == '0) ? Q_W'(1) : ss_rd;
		x_k   = x_q[k_q];
		xmag  = x_k[X_W-1] ? (~x_k + 1'b1) : x_k;
		z_k   = z_q[k_q];
		zmag  = z_k[Q_W-1] ? (~z_k + 1'b1) : z_k;
		emag  = e_q[Q_W-1] ? (~e_q + 1'b1) : e_q;
	end

	// residual and leverage rounding
	always_comb begin
		rs_e = (acc_q + 64'sd16384) >>> 15;
		if (rs_e > 64'sd2147483647) begin
			e_sat = 32'sh7FFF_FFFF;
		end else if (rs_e < -64'sd2147483648) begin
			e_sat = 32'sh8000_0000;
		end else begin
			e_sat = Q_W'(rs_e);
		end
		rs_h = (acc_q + 64'sd268435456) >>> 29;
		if (rs_h < 0) begin
			h_sat = '0;
		end else if (rs_h > 64'sd4294967295) begin
			h_sat = '1;
		end else begin
			h_sat = Q_W'(rs_h);
		end
		h_plus = {1'b0, ONE_Q16} + {1'b0, h_q};
	end

	// coefficient step and sum of squares
	always_comb begin
		if (z_k[Q_W-1] != e_q[Q_W-1]) begin
			b_sum = 34'(b_cur_q) - $signed({2'b00, div_stat.quo});
		end else begin
			b_sum = 34'(b_cur_q) + $signed({2'b00, div_stat.quo});
		end
		if (b_sum > 34'sd2147483647) begin
			b_new = 32'sh7FFF_FFFF;
		end else if (b_sum < -34'sd2147483648) begin
			b_new = 32'sh8000_0000;
		end else begin
			b_new = Q_W'(b_sum);
		end
		ss_sum = {1'b0, ss_cur_q} + 33'(sq_q);
		ss_new = ss_sum[32] ? '1 : ss_sum[Q_W-1:0];
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_E_RD;
			ST_E_RD:   state_d = ST_E_MUL;
			ST_E_MUL:  state_d = ST_E_ACC;
			ST_E_ACC:  state_d = (k_q == LAST_K) ? ST_E_FIN : ST_E_RD;
			ST_E_FIN:  state_d = ST_Z_RD;
			ST_Z_RD:   state_d = ST_Z_DIV;
			ST_Z_DIV:  state_d = ST_Z_WAIT;
			ST_Z_WAIT: if (div_stat.done) state_d = ST_Z_MUL;
			ST_Z_MUL:  state_d = ST_Z_ACC;
			ST_Z_ACC:  state_d = (k_q == LAST_K) ? ST_H_FIN : ST_Z_RD;
			ST_H_FIN:  state_d = ST_U_RD;
			ST_U_RD:   state_d = ST_U_MUL;
			ST_U_MUL:  state_d = ST_U_DIV;
			ST_U_DIV:  state_d = ST_U_WAIT;
			ST_U_WAIT: if (div_stat.done) state_d = ST_U_WR;
			ST_U_WR:   state_d = (k_q == LAST_K) ? ST_DONE : ST_U_RD;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall      = 1'b1;
		ram_we        = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = (64'(xmag) << 31) + 64'(d_rd[Q_W-1:1]);
		div_req.den   = DIV_DEN_W'(d_rd);
		case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_Z_DIV: div_req.start = 1'b1;
			ST_U_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = m_q + 64'(den_q[DIV_DEN_W-1:1]);
				div_req.den   = den_q;
			end
			ST_U_WR:  ram_we = 1'b1;
			default:  ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			k_q               <= '0;
			active_features_q <= ACTIVE_RESET;
			entry_valid_q     <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				active_features_q <= cfg_data;
			end
			if (in_acc && clear_fit) begin
				entry_valid_q <= '0;
			end
			if (state_q == ST_U_WR) begin
				entry_valid_q[k_q] <= 1'b1;
			end
			// index walks the entries in each pass
			case (state_q)
				ST_IDLE, ST_E_FIN, ST_H_FIN: k_q <= '0;
				ST_E_ACC, ST_Z_ACC, ST_U_WR: if (k_q != LAST_K) k_q <= k_q + 1'b1;
				default: ;
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_acc) begin
				x_q   <= x_in;
				acc_q <= 64'(target) <<< 16;
			end
			ST_E_MUL:  prod_q <= x_k * b_rd;
			ST_E_ACC:  acc_q <= acc_q - 64'(prod_q);
			ST_E_FIN: begin
				e_q   <= e_sat;
				acc_q <= '0;
			end
			ST_Z_WAIT: if (div_stat.done) begin
				z_q[k_q] <= x_k[X_W-1] ? -$signed(div_stat.quo) : $signed(div_stat.quo);
			end
			ST_Z_MUL:  prod_q <= x_k * z_k;
			ST_Z_ACC:  acc_q <= acc_q + 64'(prod_q);
			ST_H_FIN:  h_q <= h_sat;
			ST_U_RD:   den_q <= {1'b0, h_plus, 14'b0};
			ST_U_MUL: begin
				b_cur_q  <= b_rd;
				ss_cur_q <= ss_rd;
				m_q      <= zmag * emag;
			end
			ST_U_DIV:  sq_q <= 17'((32'(xmag) * 32'(xmag) + 32'd8192) >> 14);
			ST_U_WR:   coef_work_q[k_q] <= b_new;
			ST_DONE: if (out_free) begin
				residual_q <= e_q;
				leverage_q <= h_q;
				out_coef_q <= coef_work_q;
			end
			default: ;
		endcase
	end

	a_clear_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && clear_fit) |=> (entry_valid_q == '0))
		else $error("clear did not drop entry valid bits");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the finish state");
	a_last_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_U_WR && k_q == LAST_K) |=> (state_q == ST_DONE))
		else $error("update pass did not finish after last entry");
	a_wait_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Z_DIV || state_q == ST_U_DIV) |=> div_stat.busy)
		else $error("divider not running after start");

endmodule
`default_nettype wire
